### src/mm_pkg.sv
package mm_pkg;

  localparam int unsigned MAX_DIM_DEF    = 8;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  localparam int unsigned DimW  = 4;   // configuration register width
  localparam int unsigned IdxW  = 3;   // row / column index width
  localparam int unsigned InW   = 32;  // element port width
  localparam int unsigned OutW  = 32;  // product port width
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgW  = 2;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_START  = 2'd2
  } kind_e;

  typedef enum logic [CfgW-1:0] {
    CFG_ROWS_A  = 2'd0,
    CFG_INNER_A = 2'd1,
    CFG_ROWS_B  = 2'd2,
    CFG_COLS_B  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] ra;
    logic [DimW-1:0] ia;
    logic [DimW-1:0] cb;
  } dims_t;

  // travels with each multiply-accumulate step through the MAC pipeline
  typedef struct packed {
    logic            valid;
    logic            first;  // k == 0, restart the sum
    logic            fin;    // k == inner - 1, sum complete
    logic            last;   // final product of the start
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [IdxW-1:0] k;
  } issue_t;

  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [OutW-1:0] sum;
  } result_t;

  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] d, int unsigned lim);
    return (32'(d) > lim) ? DimW'(lim) : d;
  endfunction

endpackage

### src/mm_store.sv
module mm_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [DataW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic signed [DataW-1:0] rdata_o
);

  logic signed [DataW-1:0] mem [Depth];
  logic [Depth-1:0]        vld_q;
  logic signed [DataW-1:0] rd_q;
  logic                    rd_vld_q;

  // per-entry valid bits give the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q     <= mem[raddr_i];
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

### src/mm_mac.sv
module mm_mac #(
  parameter int unsigned StoreW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  mm_pkg::tag_t             tag_i,
  input  logic signed [StoreW-1:0] a_data_i,
  input  logic signed [StoreW-1:0] b_data_i,
  output mm_pkg::result_t          res_o
);
  import mm_pkg::*;

  tag_t                   s1_q, s2_q;
  logic signed [OutW-1:0] a_ext, b_ext;
  logic signed [OutW-1:0] mul_q, mul_d;
  logic signed [OutW-1:0] acc_q, acc_d;
  logic signed [StoreW-1:0] sum_trunc;

  // s1: store read data lines up with s1_q; s2: product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= tag_i;
      s2_q <= s1_q;
    end
  end

  assign a_ext = OutW'(a_data_i);
  assign b_ext = OutW'(b_data_i);
  assign mul_d = OutW'(a_ext * b_ext);

  assign acc_d = (s2_q.first ? '0 : acc_q) + mul_q;

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_q.valid) begin
      mul_q <= mul_d;
    end
    if (adv_i && s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  // wrap at the element width, then sign extend to the port
  assign sum_trunc = StoreW'(acc_d);

  always_comb begin
    res_o.valid = s2_q.valid && s2_q.fin;
    res_o.last  = s2_q.last;
    res_o.row   = s2_q.row;
    res_o.col   = s2_q.col;
    res_o.sum   = OutW'(sum_trunc);
  end

endmodule

### src/mm_seq.sv
module mm_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          dim_err_i,
  input  mm_pkg::dims_t dims_i,
  input  logic          adv_i,
  input  logic          drain_done_i,
  output logic          busy_o,
  output logic          err_load_o,
  output mm_pkg::issue_t issue_o
);
  import mm_pkg::*;

  localparam logic [1:0] SeqIdle  = 2'd0;
  localparam logic [1:0] SeqRun   = 2'd1;
  localparam logic [1:0] SeqDrain = 2'd2;
  localparam logic [1:0] SeqErr   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            i_end, j_end, k_end;

  assign i_end = (DimW'(i_q) + DimW'(1)) == dims_i.ra;
  assign j_end = (DimW'(j_q) + DimW'(1)) == dims_i.cb;
  assign k_end = (DimW'(k_q) + DimW'(1)) == dims_i.ia;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      SeqIdle: begin
        if (start_i) begin
          state_d = dim_err_i ? SeqErr : SeqRun;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      SeqRun: begin
        if (adv_i) begin
          if (k_end) begin
            k_d = '0;
            if (j_end) begin
              j_d = '0;
              i_d = i_q + IdxW'(1);
              if (i_end) begin
                state_d = SeqDrain;
              end
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end else begin
            k_d = k_q + IdxW'(1);
          end
        end
      end
      SeqDrain: begin
        if (drain_done_i) begin
          state_d = SeqIdle;
        end
      end
      SeqErr: begin
        if (adv_i) begin
          state_d = SeqIdle;
        end
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign busy_o     = state_q != SeqIdle;
  assign err_load_o = (state_q == SeqErr) && adv_i;

  always_comb begin
    issue_o.tag.valid = state_q == SeqRun;
    issue_o.tag.first = k_q == '0;
    issue_o.tag.fin   = k_end;
    issue_o.tag.last  = k_end && j_end && i_end;
    issue_o.tag.row   = i_q;
    issue_o.tag.col   = j_q;
    issue_o.k         = k_q;
  end

endmodule

### src/matrix_multiply_core.sv
// Dense integer matrix multiply C = A * B with one shared 32x32 multiply-accumulate
// unit. Load transactions (kind 0 for A, 1 for B) write one element and give no
// result; loads outside the configured dimensions are dropped. Both stores read as
// zero after reset (per-entry valid bits, no clearing pass). A start transaction
// (kind 2) stalls the input until it is done: while the output does not stall it
// steps the MAC once per cycle over rows_a * cols_b * inner_a terms, plus the
// multiply and accumulate stages after the last store read, emitting products in
// row-major order with the last one flagged. If rows_b differs from inner_a, or a
// dimension is zero, a single result with dim_error and last set is given instead.
// Output stall freezes the whole MAC pipeline. Sums wrap at ELEM_WIDTH bits, or at
// 32 bits if ELEM_WIDTH is larger, and the product port carries their low 32 bits.
// Configuration writes are always ready and must be made while the block is idle.
module matrix_multiply_core #(
  parameter int unsigned MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mm_pkg::CfgW-1:0]        cfg_index_i,
  input  logic [mm_pkg::DimW-1:0]        cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mm_pkg::KindW-1:0]       kind_i,
  input  logic [mm_pkg::IdxW-1:0]        row_index_i,
  input  logic [mm_pkg::IdxW-1:0]        col_index_i,
  input  logic signed [mm_pkg::InW-1:0]  element_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [mm_pkg::OutW-1:0] product_o,
  output logic [mm_pkg::IdxW-1:0]        out_row_o,
  output logic [mm_pkg::IdxW-1:0]        out_col_o,
  output logic                           dim_error_o,
  output logic                           last_o
);
  import mm_pkg::*;

  // only the low 32 bits of a sum reach the port, so wider elements keep 32 bits
  localparam int unsigned StoreW = (ELEM_WIDTH < OutW) ? ELEM_WIDTH : OutW;
  localparam int unsigned Depth  = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DimW-1:0] rows_a_q, inner_a_q, rows_b_q, cols_b_q;
  dims_t           dims;
  logic [DimW-1:0] rb_eff;

  logic            in_acc, start, dim_err, we_a, we_b, adv;
  logic            busy, err_load, drain_done, res_load;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;
  logic signed [StoreW-1:0] wdata, a_rdata, b_rdata;
  issue_t          issue;
  result_t         res;

  logic                   out_valid_q, out_valid_d;
  logic signed [OutW-1:0] product_q;
  logic [IdxW-1:0]        out_row_q, out_col_q;
  logic                   dim_error_q, last_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q  <= DimW'(8);
      inner_a_q <= DimW'(8);
      rows_b_q  <= DimW'(8);
      cols_b_q  <= DimW'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROWS_A:  rows_a_q  <= cfg_data_i;
        CFG_INNER_A: inner_a_q <= cfg_data_i;
        CFG_ROWS_B:  rows_b_q  <= cfg_data_i;
        CFG_COLS_B:  cols_b_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dims.ra = eff_dim(rows_a_q, MAX_DIM);
  assign dims.ia = eff_dim(inner_a_q, MAX_DIM);
  assign dims.cb = eff_dim(cols_b_q, MAX_DIM);
  assign rb_eff  = eff_dim(rows_b_q, MAX_DIM);

  // input decode
  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    start = 1'b0;
    we_a  = 1'b0;
    we_b  = 1'b0;
    case (kind_i)
      KIND_LOAD_A: we_a  = in_acc && (DimW'(row_index_i) < dims.ra)
                                  && (DimW'(col_index_i) < dims.ia);
      KIND_LOAD_B: we_b  = in_acc && (DimW'(row_index_i) < rb_eff)
                                  && (DimW'(col_index_i) < dims.cb);
      KIND_START:  start = in_acc;
      default: ;
    endcase
  end

  assign dim_err = (rows_b_q != inner_a_q) || (dims.ra == '0) || (dims.ia == '0)
                || (dims.cb == '0);

  assign wdata   = StoreW'(element_i);
  assign waddr   = AddrW'(32'(row_index_i) * MAX_DIM + 32'(col_index_i));
  assign a_raddr = AddrW'(32'(issue.tag.row) * MAX_DIM + 32'(issue.k));
  assign b_raddr = AddrW'(32'(issue.k) * MAX_DIM + 32'(issue.tag.col));

  // the whole MAC pipeline moves only when the output register can take a result
  assign adv = !out_valid_q || !out_stall_i;

  mm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .dim_err_i    (dim_err),
    .dims_i       (dims),
    .adv_i        (adv),
    .drain_done_i (drain_done),
    .busy_o       (busy),
    .err_load_o   (err_load),
    .issue_o      (issue)
  );

  mm_store #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (StoreW)
  ) u_store_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_store #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (StoreW)
  ) u_store_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mm_mac #(
    .StoreW (StoreW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .tag_i    (issue.tag),
    .a_data_i (a_rdata),
    .b_data_i (b_rdata),
    .res_o    (res)
  );

  assign res_load    = adv && res.valid;
  assign drain_done  = res_load && res.last;
  assign out_valid_d = adv ? (res_load || err_load) : out_valid_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      product_q   <= res.sum;
      out_row_q   <= res.row;
      out_col_q   <= res.col;
      dim_error_q <= 1'b0;
      last_q      <= res.last;
    end else if (err_load) begin
      product_q   <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      dim_error_q <= 1'b1;
      last_q      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign dim_error_o = dim_error_q;
  assign last_o      = last_q;

  // pipeline is empty whenever new input is taken
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res.valid)
    else $error("MAC pipeline holds a result while input is open");

  // error result never collides with a product
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_load |-> !res.valid)
    else $error("error result overlaps a product");

  // an error result always closes its start
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dim_error_o |-> last_o && (product_o == '0))
    else $error("error result malformed");

endmodule
